// ----- hw/rtl/dpb_pkg.sv -----
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types and constants for the depth pixel back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

  // Size limits of the depth raster.
  localparam int MaxColumnsDefault = 4096;
  localparam int MaxRowsDefault    = 4096;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_FOCAL_X      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL_Y      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_X     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 3'd5;

  // Register widths and reset values.
  localparam int IntrW = 16;
  localparam int SizeW = 13;

  localparam logic [IntrW-1:0] FOCAL_X_RST  = 16'd9600;
  localparam logic [IntrW-1:0] FOCAL_Y_RST  = 16'd9600;
  localparam logic [IntrW-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [IntrW-1:0] CENTER_Y_RST = 16'd3840;
  localparam logic [SizeW-1:0] WIDTH_RST    = 13'd640;
  localparam logic [SizeW-1:0] HEIGHT_RST   = 13'd480;

  // Payload widths.
  localparam int DepthW = 16;
  localparam int ColorW = 8;
  localparam int CoordW = 32;
  localparam int IndexW = 24;

  // Arithmetic: numerator is 16*z*|d| + f/2, which needs 37 bits.
  localparam int ProdW    = 2 * IntrW;
  localparam int NumW     = ProdW + 5;
  localparam int DivSteps = NumW;
  localparam int StepCntW = $clog2(DivSteps);

  // Controller to datapath.
  typedef struct packed {
    logic advance;   // accepted pixel: step the raster counters
    logic capture;   // accepted pixel with depth: latch operands
    logic mul;       // form the two numerators
    logic div_step;  // one restoring division step in both lanes
    logic out_load;  // move the quotients into the output register
  } dpb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic depth_nz;  // depth of the offered pixel is nonzero
  } dpb_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpb_ctrl
// Sequencer for the back-projection datapath and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire dpb_pkg::dpb_status_t status,
  output dpb_pkg::dpb_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dpb_pkg::StepCntW-1:0]    step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            in_fire;
  logic                            out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.advance = 1'b1;
          if (status.depth_nz) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == dpb_pkg::StepCntW'(dpb_pkg::DivSteps - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dpb_datapath.sv -----
// ----------------------------------------------------------------------------
// dpb_datapath
// Configuration registers, raster counters, multipliers, two restoring
// dividers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_datapath #(
  parameter int MAX_COLUMNS = dpb_pkg::MaxColumnsDefault,
  parameter int MAX_ROWS    = dpb_pkg::MaxRowsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [dpb_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [dpb_pkg::CfgDataW-1:0]  cfg_wdata,
  input  wire logic [dpb_pkg::DepthW-1:0]    in_depth_mm,
  input  wire logic [dpb_pkg::ColorW-1:0]    in_red_in,
  input  wire logic [dpb_pkg::ColorW-1:0]    in_green_in,
  input  wire logic [dpb_pkg::ColorW-1:0]    in_blue_in,
  output logic signed [dpb_pkg::CoordW-1:0]  out_point_x,
  output logic signed [dpb_pkg::CoordW-1:0]  out_point_y,
  output logic [dpb_pkg::DepthW-1:0]         out_point_z,
  output logic [dpb_pkg::ColorW-1:0]         out_red_out,
  output logic [dpb_pkg::ColorW-1:0]         out_green_out,
  output logic [dpb_pkg::ColorW-1:0]         out_blue_out,
  output logic [dpb_pkg::IndexW-1:0]         out_point_index,
  input  wire dpb_pkg::dpb_cmd_t             cmd,
  output dpb_pkg::dpb_status_t               status
);

  localparam int ColW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SizeW = dpb_pkg::SizeW;
  localparam int IntrW = dpb_pkg::IntrW;
  localparam int NumW  = dpb_pkg::NumW;
  localparam int CoordW = dpb_pkg::CoordW;

  // Configuration registers.
  logic [IntrW-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [SizeW-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= dpb_pkg::FOCAL_X_RST;
      focal_y_r  <= dpb_pkg::FOCAL_Y_RST;
      center_x_r <= dpb_pkg::CENTER_X_RST;
      center_y_r <= dpb_pkg::CENTER_Y_RST;
      width_r    <= dpb_pkg::WIDTH_RST;
      height_r   <= dpb_pkg::HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dpb_pkg::CFG_FOCAL_X:      focal_x_r  <= cfg_wdata;
        dpb_pkg::CFG_FOCAL_Y:      focal_y_r  <= cfg_wdata;
        dpb_pkg::CFG_CENTER_X:     center_x_r <= cfg_wdata;
        dpb_pkg::CFG_CENTER_Y:     center_y_r <= cfg_wdata;
        dpb_pkg::CFG_IMAGE_WIDTH:  width_r    <= cfg_wdata[SizeW-1:0];
        dpb_pkg::CFG_IMAGE_HEIGHT: height_r   <= cfg_wdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size and divisors.
  logic [SizeW-1:0] eff_w, eff_h;
  logic [IntrW-1:0] div_x, div_y;

  assign eff_w = (width_r == '0) ? SizeW'(1) :
                 (width_r > SizeW'(MAX_COLUMNS)) ? SizeW'(MAX_COLUMNS) : width_r;
  assign eff_h = (height_r == '0) ? SizeW'(1) :
                 (height_r > SizeW'(MAX_ROWS)) ? SizeW'(MAX_ROWS) : height_r;
  assign div_x = (focal_x_r == '0) ? IntrW'(1) : focal_x_r;
  assign div_y = (focal_y_r == '0) ? IntrW'(1) : focal_y_r;

  assign status.depth_nz = (in_depth_mm != '0);

  // Raster counters.
  logic [ColW-1:0]            col_r;
  logic [RowW-1:0]            row_r;
  logic [dpb_pkg::IndexW-1:0] emit_r;
  logic                       col_wrap, row_wrap;

  assign col_wrap = (SizeW'(col_r) + SizeW'(1)) >= eff_w;
  assign row_wrap = (SizeW'(row_r) + SizeW'(1)) >= eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      emit_r <= '0;
    end else if (cmd.advance) begin
      if (col_wrap) begin
        col_r <= '0;
        if (row_wrap) begin
          row_r <= '0;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
      if (col_wrap && row_wrap) begin
        emit_r <= '0;
      end else if (cmd.capture) begin
        emit_r <= emit_r + 1'b1;
      end
    end
  end

  // Operand capture: signed offset from the principal point in 1/16 px.
  logic [IntrW-1:0]           pos_x16, pos_y16;
  logic [IntrW-1:0]           mag_x_r, mag_y_r;
  logic                       neg_x_r, neg_y_r;
  logic [dpb_pkg::DepthW-1:0] z_r;
  logic [dpb_pkg::ColorW-1:0] red_r, green_r, blue_r;
  logic [dpb_pkg::IndexW-1:0] idx_r;

  assign pos_x16 = IntrW'({col_r, 4'b0000});
  assign pos_y16 = IntrW'({row_r, 4'b0000});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      neg_x_r <= pos_x16 < center_x_r;
      neg_y_r <= pos_y16 < center_y_r;
      mag_x_r <= (pos_x16 < center_x_r) ? (center_x_r - pos_x16) : (pos_x16 - center_x_r);
      mag_y_r <= (pos_y16 < center_y_r) ? (center_y_r - pos_y16) : (pos_y16 - center_y_r);
      z_r     <= in_depth_mm;
      red_r   <= in_red_in;
      green_r <= in_green_in;
      blue_r  <= in_blue_in;
      idx_r   <= emit_r;
    end
  end

  // Numerators and restoring division, one quotient bit per cycle per lane.
  logic [dpb_pkg::ProdW-1:0] prod_x, prod_y;
  logic [NumW-1:0]           quo_x_r, quo_y_r;
  logic [IntrW-1:0]          rem_x_r, rem_y_r;
  logic [IntrW:0]            sh_x, sh_y, df_x, df_y;

  assign prod_x = z_r * mag_x_r;
  assign prod_y = z_r * mag_y_r;

  assign sh_x = {rem_x_r, quo_x_r[NumW-1]};
  assign sh_y = {rem_y_r, quo_y_r[NumW-1]};
  assign df_x = sh_x - {1'b0, div_x};
  assign df_y = sh_y - {1'b0, div_y};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_x_r <= NumW'({prod_x, 4'b0000}) + NumW'(div_x >> 1);
      quo_y_r <= NumW'({prod_y, 4'b0000}) + NumW'(div_y >> 1);
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (cmd.div_step) begin
      if (sh_x >= {1'b0, div_x}) begin
        rem_x_r <= df_x[IntrW-1:0];
        quo_x_r <= {quo_x_r[NumW-2:0], 1'b1};
      end else begin
        rem_x_r <= sh_x[IntrW-1:0];
        quo_x_r <= {quo_x_r[NumW-2:0], 1'b0};
      end
      if (sh_y >= {1'b0, div_y}) begin
        rem_y_r <= df_y[IntrW-1:0];
        quo_y_r <= {quo_y_r[NumW-2:0], 1'b1};
      end else begin
        rem_y_r <= sh_y[IntrW-1:0];
        quo_y_r <= {quo_y_r[NumW-2:0], 1'b0};
      end
    end
  end

  // Sign and saturation to 32 bits.
  localparam logic [NumW-1:0]   PosMax = NumW'(32'h7FFF_FFFF);
  localparam logic [NumW-1:0]   NegMax = NumW'(33'h1_0000_0000) >> 1;
  localparam logic [CoordW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] SatNeg = 32'h8000_0000;

  logic [CoordW-1:0] sat_x, sat_y;

  always_comb begin
    if (neg_x_r) begin
      sat_x = (quo_x_r >= NegMax) ? SatNeg : (CoordW'(0) - quo_x_r[CoordW-1:0]);
    end else begin
      sat_x = (quo_x_r > PosMax) ? SatPos : quo_x_r[CoordW-1:0];
    end
    if (neg_y_r) begin
      sat_y = (quo_y_r >= NegMax) ? SatNeg : (CoordW'(0) - quo_y_r[CoordW-1:0]);
    end else begin
      sat_y = (quo_y_r > PosMax) ? SatPos : quo_y_r[CoordW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_point_x     <= sat_x;
      out_point_y     <= sat_y;
      out_point_z     <= z_r;
      out_red_out     <= red_r;
      out_green_out   <= green_r;
      out_blue_out    <= blue_r;
      out_point_index <= idx_r;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/depth_pixel_backprojection.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Turns a raster stream of depth pixels into colored 3-D points.
// ----------------------------------------------------------------------------
// Each beat on the input channel is one depth pixel (millimeters) with its
// color, in raster order; column, row and point counters follow the raster and
// wrap at the programmed image size. A pixel with zero depth produces no point
// and does not stall the input. Any other pixel produces one point with
// z = depth, x = round(16*z*(16*col - center_x)/focal_x) and the same for y in
// 1/16 mm, saturated to signed 32 bits, together with its color and its index
// within the frame. The operands are latched at the edge that accepts the
// pixel, the multipliers then form the numerators, the bit-per-cycle
// restoring dividers form x and y side by side, and the result is then
// loaded into the output register. The next pixel is accepted in the
// cycle after the result is loaded, even while that result still waits on
// the output, so a pixel with depth is not taken until the point before it
// has been loaded; a result that is still waiting when the next one is
// ready holds the block until it leaves. Write the configuration registers
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_backprojection #(
  parameter int MAX_COLUMNS = dpb_pkg::MaxColumnsDefault,
  parameter int MAX_ROWS    = dpb_pkg::MaxRowsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration write port.
  input  wire logic                          cfg_wr_en,
  input  wire logic [dpb_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [dpb_pkg::CfgDataW-1:0]  cfg_wdata,
  // Pixel input channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dpb_pkg::DepthW-1:0]    in_depth_mm,
  input  wire logic [dpb_pkg::ColorW-1:0]    in_red_in,
  input  wire logic [dpb_pkg::ColorW-1:0]    in_green_in,
  input  wire logic [dpb_pkg::ColorW-1:0]    in_blue_in,
  // Point output channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [dpb_pkg::CoordW-1:0]  out_point_x,
  output logic signed [dpb_pkg::CoordW-1:0]  out_point_y,
  output logic [dpb_pkg::DepthW-1:0]         out_point_z,
  output logic [dpb_pkg::ColorW-1:0]         out_red_out,
  output logic [dpb_pkg::ColorW-1:0]         out_green_out,
  output logic [dpb_pkg::ColorW-1:0]         out_blue_out,
  output logic [dpb_pkg::IndexW-1:0]         out_point_index
);

  dpb_pkg::dpb_cmd_t    cmd;
  dpb_pkg::dpb_status_t status;

  // The controller sequences one pixel at a time and owns the output valid.
  dpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds configuration, counters, arithmetic and the payload.
  dpb_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_depth_mm     (in_depth_mm),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_point_index (out_point_index),
    .cmd             (cmd),
    .status          (status)
  );

  // A pixel without depth never stalls the input.
  a_zero_depth_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_depth_mm == '0) |=> in_ready)
    else $error("input stalled after a zero-depth pixel");

  // A pixel with depth keeps the block busy while its point is computed.
  a_depth_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_depth_mm != '0) |=> !in_ready)
    else $error("input accepted while a point is being computed");

  // Every point carries a nonzero depth.
  a_point_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_z != '0))
    else $error("point with zero depth on the output");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth pixel back-projection block.
// ----------------------------------------------------------------------------
// Streams depth pixels with random color into the block and predicts every
// point in a behavioral model that keeps its own raster counters and its own
// copy of the intrinsics. A checker process compares each point beat that
// leaves the block, field by field, against the oldest prediction. Directed
// tests come first: reset intrinsics, degenerate and oversized image sizes, a
// zero focal length, frame ends, a resize in the middle of a frame, rounding
// ties and saturation. A long random stream follows over several settings.
// Both channels idle at random, except for one phase that runs flat out.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // This is the quiet time before a register write and at the end of the run.
  localparam int SettleCycles = 60;
  localparam int PixelsPerPhase = 258;

  typedef struct {
    logic signed [dpb_pkg::CoordW-1:0] x;
    logic signed [dpb_pkg::CoordW-1:0] y;
    logic [dpb_pkg::DepthW-1:0]        z;
    logic [dpb_pkg::ColorW-1:0]        red;
    logic [dpb_pkg::ColorW-1:0]        green;
    logic [dpb_pkg::ColorW-1:0]        blue;
    logic [dpb_pkg::IndexW-1:0]        point_no;
  } point_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [dpb_pkg::CfgIdxW-1:0]       cfg_index = '0;
  logic [dpb_pkg::CfgDataW-1:0]      cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [dpb_pkg::DepthW-1:0]        in_depth_mm = '0;
  logic [dpb_pkg::ColorW-1:0]        in_red_in = '0;
  logic [dpb_pkg::ColorW-1:0]        in_green_in = '0;
  logic [dpb_pkg::ColorW-1:0]        in_blue_in = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [dpb_pkg::CoordW-1:0] out_point_x;
  logic signed [dpb_pkg::CoordW-1:0] out_point_y;
  logic [dpb_pkg::DepthW-1:0]        out_point_z;
  logic [dpb_pkg::ColorW-1:0]        out_red_out;
  logic [dpb_pkg::ColorW-1:0]        out_green_out;
  logic [dpb_pkg::ColorW-1:0]        out_blue_out;
  logic [dpb_pkg::IndexW-1:0]        out_point_index;

  // Intrinsics and raster position as the block should hold them.
  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [12:0] width_q, height_q;
  logic [11:0] col_pos, row_pos;
  logic [23:0] point_count;

  point_t pending_points[$];
  int     mismatches = 0;
  bit     tx_gaps = 1'b1;
  bit     rx_stalls = 1'b1;

  depth_pixel_backprojection dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_depth_mm     (in_depth_mm),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_point_index (out_point_index)
  );

  always #6 clk = ~clk;

  // The run must never hang; this bound is several times the slowest legal run.
  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A size of zero counts as one; anything above the raster limit is clipped.
  function automatic int clamp_size(input logic [12:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // One camera axis: round(16*z*(16*pos - center)/focal), ties away from zero,
  // then clipped to signed 32 bits. A zero focal length acts as one.
  function automatic logic signed [31:0] project_axis(input logic [15:0] z,
                                                      input logic [11:0] pos,
                                                      input logic [15:0] center,
                                                      input logic [15:0] focal);
    longint unsigned pos16, f, mag, num, q;
    bit neg;
    pos16 = 64'(pos) * 64'd16;
    f = (focal == 0) ? 64'd1 : 64'(focal);
    neg = pos16 < 64'(center);
    mag = neg ? (64'(center) - pos16) : (pos16 - 64'(center));
    num = 64'd16 * 64'(z) * mag;
    q = (num + f / 64'd2) / f;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      q = ~q + 64'd1;
      return q[31:0];
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return q[31:0];
  endfunction

  // Consumes one pixel at the current raster position. Returns 1 and the point
  // when the depth is nonzero, and steps the counters in either case.
  function automatic bit backproject_pixel(input logic [15:0] depth,
                                           input logic [7:0] red,
                                           input logic [7:0] green,
                                           input logic [7:0] blue,
                                           output point_t pt);
    int w, h;
    bit hit;
    w = clamp_size(width_q, dpb_pkg::MaxColumnsDefault);
    h = clamp_size(height_q, dpb_pkg::MaxRowsDefault);
    hit = (depth != 0);
    pt.x = project_axis(depth, col_pos, center_x_q, focal_x_q);
    pt.y = project_axis(depth, row_pos, center_y_q, focal_y_q);
    pt.z = depth;
    pt.red = red;
    pt.green = green;
    pt.blue = blue;
    pt.point_no = point_count;
    if (hit) point_count = point_count + 24'd1;
    // A counter at or past the last position wraps, even after a resize.
    if (int'(col_pos) + 1 >= w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= h) begin
        row_pos = '0;
        point_count = '0;
      end else begin
        row_pos = row_pos + 12'd1;
      end
    end else begin
      col_pos = col_pos + 12'd1;
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  task automatic write_reg(input logic [dpb_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dpb_pkg::CFG_FOCAL_X:      focal_x_q = val;
      dpb_pkg::CFG_FOCAL_Y:      focal_y_q = val;
      dpb_pkg::CFG_CENTER_X:     center_x_q = val;
      dpb_pkg::CFG_CENTER_Y:     center_y_q = val;
      dpb_pkg::CFG_IMAGE_WIDTH:  width_q = val[12:0];
      dpb_pkg::CFG_IMAGE_HEIGHT: height_q = val[12:0];
      default: ;
    endcase
  endtask

  // Writes all six registers on consecutive cycles. Only call while idle.
  task automatic program_regs(input logic [15:0] fx, input logic [15:0] fy,
                              input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] w, input logic [15:0] h);
    write_reg(dpb_pkg::CFG_FOCAL_X, fx);
    write_reg(dpb_pkg::CFG_FOCAL_Y, fy);
    write_reg(dpb_pkg::CFG_CENTER_X, cx);
    write_reg(dpb_pkg::CFG_CENTER_Y, cy);
    write_reg(dpb_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(dpb_pkg::CFG_IMAGE_HEIGHT, h);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one pixel beat, optionally after an idle gap, and records the point
  // it should produce once the beat is taken.
  task automatic send_pixel(input logic [15:0] depth, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    point_t pt;
    if (tx_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      // Mostly short gaps, now and then one long enough to span a whole point.
      repeat (($urandom_range(9) == 0) ? $urandom_range(50, 4) : $urandom_range(3, 1))
        @(posedge clk);
    end
    in_valid <= 1'b1;
    in_depth_mm <= depth;
    in_red_in <= red;
    in_green_in <= green;
    in_blue_in <= blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (backproject_pixel(depth, red, green, blue, pt)) pending_points = {pending_points, pt};
  endtask

  task automatic send_random_pixel();
    logic [15:0] depth;
    case ($urandom_range(19))
      0, 1, 2: depth = '0;
      3:       depth = 16'hFFFF;
      4:       depth = 16'd1;
      default: depth = 16'($urandom_range(65535, 1));
    endcase
    send_pixel(depth, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
  endtask

  // Drops valid and waits until every predicted point is out and the block has
  // had time to finish any pixel still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Checker: out_ready is re-drawn every cycle, and a beat is taken when valid
  // and ready were both high before the edge.
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : point_checker
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        $display("%0t: point beat with none expected, expected nothing, actual index %0h",
                 $time, out_point_index);
      end else begin
        want = pending_points.pop_front();
        check_field("point_x", want.x, out_point_x);
        check_field("point_y", want.y, out_point_y);
        check_field("point_z", 32'(want.z), 32'(out_point_z));
        check_field("red_out", 32'(want.red), 32'(out_red_out));
        check_field("green_out", 32'(want.green), 32'(out_green_out));
        check_field("blue_out", 32'(want.blue), 32'(out_blue_out));
        check_field("point_index", 32'(want.point_no), 32'(out_point_index));
      end
    end
    out_ready <= !(rx_stalls && $urandom_range(99) < 35);
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset intrinsics, depth and color extremes, and a pixel with no depth.
  task automatic test_reset_defaults();
    send_pixel(16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd0, 8'hAA, 8'h55, 8'hFF);
    send_pixel(16'hFFFF, 8'h55, 8'hAA, 8'h00);
  endtask

  // Image sizes of zero and above the limit, a zero focal length, frame ends
  // and a width cut below the current column in the middle of a frame.
  task automatic test_frame_sizes();
    settle();
    // Zero size acts as a 1x1 image, so every pixel ends a frame.
    program_regs(16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd0);
    send_pixel(16'd300, 8'h12, 8'h34, 8'h56);
    send_pixel(16'd0, 8'h01, 8'h02, 8'h03);
    send_pixel(16'hFFFF, 8'h80, 8'h40, 8'h20);
    settle();
    // Oversized widths clip to the raster limit; upper data bits are dropped.
    program_regs(16'd0, 16'd0, 16'd16, 16'd16, 16'hFFFF, 16'd8191);
    send_pixel(16'd1000, 8'h11, 8'h22, 8'h33);
    send_pixel(16'd2000, 8'h44, 8'h55, 8'h66);
    settle();
    // A 3x2 frame, run across its end so the index restarts.
    program_regs(16'd0, 16'd0, 16'd16, 16'd16, 16'd3, 16'd2);
    send_pixel(16'd10, 8'h01, 8'h10, 8'h7F);
    send_pixel(16'd0, 8'h02, 8'h20, 8'h7E);
    send_pixel(16'd20, 8'h04, 8'h40, 8'h7D);
    send_pixel(16'd30, 8'h08, 8'h80, 8'h7C);
    send_pixel(16'd40, 8'hFE, 8'hEF, 8'h01);
    settle();
    // Shrink the width under the current column: that pixel wraps after it.
    program_regs(16'd0, 16'd0, 16'd16, 16'd16, 16'd1, 16'd2);
    send_pixel(16'd50, 8'h9A, 8'hBC, 8'hDE);
    send_pixel(16'd60, 8'hDE, 8'hBC, 8'h9A);
  endtask

  // Exact half-way quotients on both sides of the principal point, then a
  // projection far enough off-axis to clip at the negative limit.
  task automatic test_rounding_and_saturation();
    settle();
    program_regs(16'd32, 16'd32, {col_pos, 4'd1}, {row_pos, 4'd1}, 16'd2, 16'd4096);
    send_pixel(16'd1, 8'h00, 8'hFF, 8'h0F);
    send_pixel(16'd1, 8'hFF, 8'h00, 8'hF0);
    send_pixel(16'd1, 8'h5A, 8'hA5, 8'h3C);
    settle();
    program_regs(16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd4096);
    send_pixel(16'hFFFF, 8'hC3, 8'h3C, 8'h99);
    send_pixel(16'hFFFF, 8'h66, 8'h99, 8'hC3);
  endtask

  function automatic logic [15:0] rand_focal();
    case ($urandom_range(3))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(2000, 8));
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_center();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Small images keep frame ends frequent; the limits still come up.
  function automatic logic [15:0] rand_size();
    case ($urandom_range(4))
      0:       return 16'd1;
      1:       return 16'd4096;
      default: return 16'($urandom_range(40, 2));
    endcase
  endfunction

  // Random pixels over several settings. The counters carry over from phase
  // to phase, so each new size also lands somewhere inside a frame.
  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: program_regs(16'd1000, 16'd1000, 16'd128, 16'd96, 16'd16, 16'd12);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096);
        // Tiny focal length far from the center: both saturation limits.
        2: program_regs(16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd4096, 16'd4096);
        default: program_regs(rand_focal(), rand_focal(), rand_center(), rand_center(),
                              rand_size(), rand_size());
      endcase
      // One phase runs with both sides always ready.
      tx_gaps = (phase != 3);
      rx_stalls = (phase != 3);
      for (int i = 0; i < PixelsPerPhase; i++) send_random_pixel();
    end
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    focal_x_q = 16'd9600;
    focal_y_q = 16'd9600;
    center_x_q = 16'd5120;
    center_y_q = 16'd3840;
    width_q = 13'd640;
    height_q = 13'd480;
    col_pos = '0;
    row_pos = '0;
    point_count = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_frame_sizes();
    test_rounding_and_saturation();
    test_random_stream();
    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_ctrl.sv
hw/rtl/dpb_datapath.sv
hw/rtl/depth_pixel_backprojection.sv
tb/tb.sv
